@@ rtl/urds_pkg.sv @@
// Shared types, register codes and constants for the ultrasonic ranger.
package urds_pkg;

  localparam int DistW    = 10;
  localparam int SegW     = 8;
  localparam int SelW     = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  localparam logic [DistW-1:0] MaxDist = 10'd999;
  localparam logic [SegW-1:0]  SegBlank = 8'hff;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CfgFramePeriod = 3'd0,
    CfgPulseCount  = 3'd1,
    CfgHalfPeriod  = 3'd2,
    CfgTimeout     = 3'd3,
    CfgScale       = 3'd4
  } urds_cfg_addr_e;

  localparam logic [9:0]  RstFramePeriod = 10'd100;
  localparam logic [4:0]  RstPulseCount  = 5'd8;
  localparam logic [7:0]  RstHalfPeriod  = 8'd11;
  localparam logic [15:0] RstTimeout     = 16'hffff;
  localparam logic [15:0] RstScale       = 16'd1114;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhBurst  = 2'd1,
    PhListen = 2'd2
  } urds_phase_e;

  typedef struct packed {
    logic [9:0]  frame_period;
    logic [4:0]  pulse_count;
    logic [7:0]  half_period_ticks;
    logic [15:0] timeout_limit;
    logic [15:0] scale;
  } urds_cfg_t;

  // One tick moving from the input register into the result registers.
  typedef struct packed {
    logic adv;
    logic echo;
    logic frame_tick;
  } urds_step_t;

  typedef struct packed {
    logic echo;
    logic frame_tick;
  } urds_in_t;

  typedef struct packed {
    logic             tx;
    logic [SelW-1:0]  digit_select;
    logic [SegW-1:0]  segments;
    logic [DistW-1:0] distance_cm;
    logic             measure_done;
    logic             timed_out;
  } urds_out_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] wdata;
  } urds_cfg_wr_t;

  // Active-low seven-segment font for decimal digits.
  function automatic logic [SegW-1:0] seg_font(input logic [3:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0: pat = 8'hc0;
      4'd1: pat = 8'hf9;
      4'd2: pat = 8'ha4;
      4'd3: pat = 8'hb0;
      4'd4: pat = 8'h99;
      4'd5: pat = 8'h92;
      4'd6: pat = 8'h82;
      4'd7: pat = 8'hf8;
      4'd8: pat = 8'h80;
      4'd9: pat = 8'h90;
      default: pat = SegBlank;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/urds_if.sv @@
// Handshake interfaces for the tick, result and configuration channels.
interface urds_in_if;
  logic              valid;
  logic              ready;
  urds_pkg::urds_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface urds_out_if;
  logic               valid;
  logic               ready;
  urds_pkg::urds_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface urds_cfg_if;
  logic                  valid;
  logic                  ready;
  urds_pkg::urds_cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ultrasonic_ranger_with_digit_scan.sv @@
// Top level of the ultrasonic ranger with seven-segment digit scan.
//
//   channel  modport  payload                                         direction
//   in_i     sink     echo, frame_tick                                 in
//   out_o    source   tx, digit_select, segments, distance_cm,         out
//                     measure_done, timed_out
//   cfg_i    sink     addr (register index), wdata                     in
//
// One tick is accepted every cycle while the result is not stalled. A tick waits
// in the input register and then updates all state, which doubles as the result
// register, so a result is valid once that state has been updated and stays valid
// until it transfers out.
// Reset clears all state; the configuration registers return to their defaults.
// A stalled result holds the state; one more tick can wait in the input register,
// after which in_i.ready stays low until the result transfers.
module ultrasonic_ranger_with_digit_scan #(
  parameter int DIGITS      = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  urds_in_if.sink      in_i,
  urds_out_if.source   out_o,
  urds_cfg_if.sink     cfg_i
);

  urds_pkg::urds_cfg_t  cfg;
  urds_pkg::urds_step_t step;
  urds_pkg::urds_in_t   item_q;
  logic                 item_valid_q, out_valid_q, adv;
  logic                 tx, done, timed_out;
  logic [urds_pkg::DistW-1:0] distance;
  logic [urds_pkg::SelW-1:0]  select;
  logic [urds_pkg::SegW-1:0]  segments;

  assign adv        = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        item_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
  end

  assign step.adv        = adv;
  assign step.echo       = item_q.echo;
  assign step.frame_tick = item_q.frame_tick;

  urds_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid && cfg_i.ready),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  urds_ranger #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ranger (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .tx_o        (tx),
    .distance_o  (distance),
    .done_o      (done),
    .timed_out_o (timed_out)
  );

  urds_scan #(
    .DIGITS (DIGITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .distance_i (distance),
    .select_o   (select),
    .segments_o (segments)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.data.tx           = tx;
  assign out_o.data.digit_select = select;
  assign out_o.data.segments     = segments;
  assign out_o.data.distance_cm  = distance;
  assign out_o.data.measure_done = done;
  assign out_o.data.timed_out    = timed_out;

  // A timeout always reports the saturated distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    timed_out |-> distance == urds_pkg::MaxDist)
    else $error("timeout without saturated distance");

  // The distance never leaves the displayable range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    distance <= urds_pkg::MaxDist)
    else $error("distance above display range");

  // A measurement ends only after the burst, so tx is low then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !tx)
    else $error("measurement finished while transmitting");

  // At most one digit is enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(select))
    else $error("more than one digit enabled");

endmodule

@@ rtl/urds_cfg_regs.sv @@
// Configuration register file of the ranger.
module urds_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  urds_pkg::urds_cfg_wr_t wr_i,
  output urds_pkg::urds_cfg_t    cfg_o
);

  urds_pkg::urds_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_period      <= urds_pkg::RstFramePeriod;
      cfg_q.pulse_count       <= urds_pkg::RstPulseCount;
      cfg_q.half_period_ticks <= urds_pkg::RstHalfPeriod;
      cfg_q.timeout_limit     <= urds_pkg::RstTimeout;
      cfg_q.scale             <= urds_pkg::RstScale;
    end else if (wr_en_i) begin
      case (wr_i.addr)
        urds_pkg::CfgFramePeriod: cfg_q.frame_period      <= wr_i.wdata[9:0];
        urds_pkg::CfgPulseCount:  cfg_q.pulse_count       <= wr_i.wdata[4:0];
        urds_pkg::CfgHalfPeriod:  cfg_q.half_period_ticks <= wr_i.wdata[7:0];
        urds_pkg::CfgTimeout:     cfg_q.timeout_limit     <= wr_i.wdata;
        urds_pkg::CfgScale:       cfg_q.scale             <= wr_i.wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/urds_ranger.sv @@
// Frame divider, transmit burst and echo timer of the ranger.
module urds_ranger #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urds_pkg::urds_cfg_t           cfg_i,
  input  urds_pkg::urds_step_t          step_i,
  output logic                          tx_o,
  output logic [urds_pkg::DistW-1:0]    distance_o,
  output logic                          done_o,
  output logic                          timed_out_o
);

  localparam int PW = COUNT_WIDTH + 16;
  localparam int CW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  urds_pkg::urds_phase_e phase_q, phase_d;
  logic [9:0]                   frame_q, frame_d, frame_inc;
  logic                         req_q, req_d, req_now;
  logic [4:0]                   pulses_q, pulses_d, pulses_dec;
  logic [7:0]                   half_q, half_d;
  logic                         tx_q, tx_d;
  logic [COUNT_WIDTH-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [PW-1:0]                prod;
  logic [urds_pkg::DistW-1:0]   dist_q, dist_d, dist_scaled;
  logic                         tflag_q, tflag_d, done_q, done_d;
  logic                         half_end, burst_end, cnt_sat, timeout_hit, frame_hit;
  logic [COUNT_WIDTH-1:0]       prod_hi;
  logic [CW-1:0]                prod_hi_ext;

  assign frame_inc = frame_q + 10'd1;
  assign frame_hit = step_i.frame_tick && (frame_inc == cfg_i.frame_period);
  assign req_now   = req_q || frame_hit;

  assign half_end   = ({1'b0, half_q} + 9'd1) >= {1'b0, cfg_i.half_period_ticks};
  assign pulses_dec = pulses_q - 5'd1;
  assign burst_end  = half_end && !tx_q && (pulses_dec == 5'd0);

  // The product uses the live scale, so a scale write during a listen takes effect at once.
  assign cnt_sat     = (cnt_q == CntMax);
  assign cnt_inc     = cnt_sat ? cnt_q : cnt_q + COUNT_WIDTH'(1);
  assign prod        = PW'(cnt_q) * PW'(cfg_i.scale);
  assign timeout_hit = (CW'(cnt_inc) >= CW'(cfg_i.timeout_limit)) || (cnt_inc == CntMax);

  assign prod_hi     = prod[PW-1:16];
  assign prod_hi_ext = CW'(prod_hi);
  assign dist_scaled = (prod_hi_ext > CW'(urds_pkg::MaxDist)) ? urds_pkg::MaxDist
                                                               : urds_pkg::DistW'(prod_hi_ext);

  // Next phase.
  always_comb begin
    case (phase_q)
      urds_pkg::PhBurst:  phase_d = burst_end ? urds_pkg::PhListen : urds_pkg::PhBurst;
      urds_pkg::PhListen: phase_d = (!step_i.echo || timeout_hit) ? urds_pkg::PhIdle
                                                                   : urds_pkg::PhListen;
      default:            phase_d = req_now ? urds_pkg::PhBurst : urds_pkg::PhIdle;
    endcase
  end

  // Datapath registers.
  always_comb begin
    frame_d  = frame_q;
    req_d    = req_now;
    pulses_d = pulses_q;
    half_d   = half_q;
    tx_d     = tx_q;
    cnt_d    = cnt_q;
    dist_d   = dist_q;
    tflag_d  = tflag_q;
    done_d   = 1'b0;
    if (step_i.frame_tick) begin
      frame_d = frame_hit ? 10'd0 : frame_inc;
    end
    case (phase_q)
      urds_pkg::PhBurst: begin
        if (half_end) begin
          half_d = 8'd0;
          if (tx_q) begin
            tx_d = 1'b0;
          end else begin
            pulses_d = pulses_dec;
            if (pulses_dec == 5'd0) begin
              cnt_d = '0;
            end else begin
              tx_d = 1'b1;
            end
          end
        end else begin
          half_d = half_q + 8'd1;
        end
      end
      urds_pkg::PhListen: begin
        if (!step_i.echo) begin
          dist_d  = dist_scaled;
          tflag_d = 1'b0;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_inc;
          if (timeout_hit) begin
            dist_d  = urds_pkg::MaxDist;
            tflag_d = 1'b1;
            done_d  = 1'b1;
          end
        end
      end
      default: begin
        if (req_now) begin
          req_d    = 1'b0;
          pulses_d = (cfg_i.pulse_count == 5'd0) ? 5'd1 : cfg_i.pulse_count;
          half_d   = 8'd0;
          tx_d     = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= urds_pkg::PhIdle;
      frame_q  <= '0;
      req_q    <= 1'b0;
      pulses_q <= '0;
      half_q   <= '0;
      tx_q     <= 1'b0;
      cnt_q    <= '0;
      dist_q   <= '0;
      tflag_q  <= 1'b0;
      done_q   <= 1'b0;
    end else if (step_i.adv) begin
      phase_q  <= phase_d;
      frame_q  <= frame_d;
      req_q    <= req_d;
      pulses_q <= pulses_d;
      half_q   <= half_d;
      tx_q     <= tx_d;
      cnt_q    <= cnt_d;
      dist_q   <= dist_d;
      tflag_q  <= tflag_d;
      done_q   <= done_d;
    end
  end

  assign tx_o        = tx_q;
  assign distance_o  = dist_q;
  assign done_o      = done_q;
  assign timed_out_o = tflag_q;

endmodule

@@ rtl/urds_scan.sv @@
// Seven-segment digit scan showing the last distance on the rightmost three digits.
module urds_scan #(
  parameter int DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  urds_pkg::urds_step_t        step_i,
  input  logic [urds_pkg::DistW-1:0]  distance_i,
  output logic [urds_pkg::SelW-1:0]   select_o,
  output logic [urds_pkg::SegW-1:0]   segments_o
);

  localparam int SW = $clog2(DIGITS);
  localparam logic [SW-1:0] FirstPos = SW'(DIGITS - 3);
  localparam logic [SW-1:0] LastPos  = SW'(DIGITS - 1);

  logic [SW-1:0]               idx_q, idx_d, idx_cur;
  logic [urds_pkg::SelW-1:0]   sel_q, sel_d;
  logic [urds_pkg::SegW-1:0]   seg_q, seg_d, pattern;
  logic [15:0]                 hund_mul;
  logic [3:0]                  hund, tens, units;
  logic [6:0]                  rem;
  logic [14:0]                 tens_mul;

  // Decimal digits by reciprocal multiplication; exact for values up to 999.
  assign hund_mul = 16'(distance_i) * 16'd41;
  assign hund     = hund_mul[15:12];
  assign rem      = 7'(distance_i - 10'(hund) * 10'd100);
  assign tens_mul = 15'(rem) * 15'd205;
  assign tens     = tens_mul[14:11];
  assign units    = 4'(rem - 7'(tens) * 7'd10);

  assign idx_cur = (idx_q > LastPos) ? '0 : idx_q;

  always_comb begin
    if (idx_cur < FirstPos) begin
      pattern = urds_pkg::SegBlank;
    end else if (idx_cur == FirstPos) begin
      pattern = urds_pkg::seg_font(hund);
    end else if (idx_cur == FirstPos + SW'(1)) begin
      pattern = urds_pkg::seg_font(tens);
    end else begin
      pattern = urds_pkg::seg_font(units);
    end
  end

  always_comb begin
    idx_d = idx_q;
    sel_d = sel_q;
    seg_d = seg_q;
    if (step_i.frame_tick) begin
      sel_d = urds_pkg::SelW'(1) << idx_cur;
      seg_d = pattern;
      idx_d = (idx_cur == LastPos) ? '0 : idx_cur + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sel_q <= '0;
      seg_q <= urds_pkg::SegBlank;
    end else if (step_i.adv) begin
      idx_q <= idx_d;
      sel_q <= sel_d;
      seg_q <= seg_d;
    end
  end

  assign select_o   = sel_q;
  assign segments_o = seg_q;

endmodule
